>>> sv/ttdos_pkg.sv
package ttdos_pkg;

  // Operation carried by one input transfer.
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_POLL   = 2'd1,
    OP_ORDER  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Motor command returned with each result.
  typedef enum logic [2:0] {
    CMD_KEEP     = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_FORWARD  = 3'd2,
    CMD_BACKWARD = 3'd3,
    CMD_TURN_POS = 3'd4,
    CMD_TURN_NEG = 3'd5
  } cmd_t;

  // Event code returned with each result.
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ACCEPTED = 2'd1,
    EV_REPORT   = 2'd2,
    EV_CLEARED  = 2'd3
  } ev_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LEFT_HIGH  = 3'd0,
    CFG_LEFT_LOW   = 3'd1,
    CFG_RIGHT_HIGH = 3'd2,
    CFG_RIGHT_LOW  = 3'd3,
    CFG_PULSE_STEP = 3'd4,
    CFG_FAST_AFTER = 3'd5,
    CFG_SLOW_SPEED = 3'd6,
    CFG_FAST_SPEED = 3'd7
  } cfg_idx_t;

  // Sequencer phase flags.
  typedef struct packed {
    logic run;
    logic drive;
    logic turn;
  } phase_t;

  localparam int TRAVEL_BITS_DEF = 24;

  localparam logic [12:0] LEFT_HIGH_RST  = 13'd1900;
  localparam logic [12:0] LEFT_LOW_RST   = 13'd1700;
  localparam logic [12:0] RIGHT_HIGH_RST = 13'd2550;
  localparam logic [12:0] RIGHT_LOW_RST  = 13'd2000;
  localparam logic [9:0]  PULSE_STEP_RST = 10'd139;
  localparam logic [9:0]  FAST_AFTER_RST = 10'd20;
  localparam logic [6:0]  SLOW_SPEED_RST = 7'd4;
  localparam logic [6:0]  FAST_SPEED_RST = 7'd10;

  localparam logic [6:0]  TURN_SPEED     = 7'd7;
  localparam logic [12:0] SAMPLE_OFFSET  = 13'd2;

  // floor(x / 24) == (x * 2731) >> 16 for every x up to 255 * 5.
  localparam logic [11:0] DIV24_RECIP = 12'd2731;

  // Whole turn steps of 4.8 degrees in a turn magnitude: floor(mag * 5 / 24).
  function automatic logic [5:0] turn_steps(input logic [7:0] mag);
    logic [10:0] mag5;
    logic [22:0] prod;
    mag5 = {1'b0, mag, 2'b00} + 11'(mag);
    prod = 23'(mag5) * 23'(DIV24_RECIP);
    return prod[21:16];
  endfunction

endpackage

>>> sv/turn_then_drive_odometry_sequencer_unit.sv
// Turn-then-drive odometry sequencer. Each input transfer is a sample pair
// from the two wheel sensors, a poll tick, a new order or a clear, and every
// input transfer yields exactly one result transfer carrying a motor command,
// a speed, the current heading and an event code (with the finished order's
// id, turn and distance when the event is a report). Wheel travel is kept in
// hundredths of a unit and saturates at 2**TRAVEL_BITS - 1. The block takes
// one item per clock cycle while out_ready does not stall the result register;
// each item is registered in the input register and then passes
// through the single compute stage into the result register, which also holds
// all sequencer state. The input side keeps accepting while a result waits, as
// long as the result register can move on in the same cycle. Configuration
// registers are written through the plain write port and must only be changed
// while no item is in flight; they take effect on the next item computed.
module turn_then_drive_odometry_sequencer_unit #(
  parameter int TRAVEL_BITS = ttdos_pkg::TRAVEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [11:0]        in_adc_left,
  input  logic [11:0]        in_adc_right,
  input  logic [15:0]        in_order_id,
  input  logic signed [8:0]  in_turn_degree,
  input  logic signed [15:0] in_drive_distance,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_motor_cmd,
  output logic [6:0]         out_motor_speed,
  output logic signed [8:0]  out_heading,
  output logic [1:0]         out_event_res,
  output logic [15:0]        out_report_order_id,
  output logic signed [8:0]  out_report_degree,
  output logic signed [15:0] out_report_distance,
  // Configuration port
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data
);

  // The mean-travel compares work on the sum of both wheels, which needs one
  // bit more than a single wheel and must also hold goal * 200.
  localparam int SUM_W = (TRAVEL_BITS + 1 > 24) ? TRAVEL_BITS + 1 : 24;

  // Configuration registers.
  logic [12:0] left_high_r, left_low_r, right_high_r, right_low_r;
  logic [9:0]  pulse_step_r, fast_after_r;
  logic [6:0]  slow_speed_r, fast_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_high_r  <= ttdos_pkg::LEFT_HIGH_RST;
      left_low_r   <= ttdos_pkg::LEFT_LOW_RST;
      right_high_r <= ttdos_pkg::RIGHT_HIGH_RST;
      right_low_r  <= ttdos_pkg::RIGHT_LOW_RST;
      pulse_step_r <= ttdos_pkg::PULSE_STEP_RST;
      fast_after_r <= ttdos_pkg::FAST_AFTER_RST;
      slow_speed_r <= ttdos_pkg::SLOW_SPEED_RST;
      fast_speed_r <= ttdos_pkg::FAST_SPEED_RST;
    end else if (cfg_wr_en) begin
      case (ttdos_pkg::cfg_idx_t'(cfg_index))
        ttdos_pkg::CFG_LEFT_HIGH:  left_high_r  <= cfg_data;
        ttdos_pkg::CFG_LEFT_LOW:   left_low_r   <= cfg_data;
        ttdos_pkg::CFG_RIGHT_HIGH: right_high_r <= cfg_data;
        ttdos_pkg::CFG_RIGHT_LOW:  right_low_r  <= cfg_data;
        ttdos_pkg::CFG_PULSE_STEP: pulse_step_r <= cfg_data[9:0];
        ttdos_pkg::CFG_FAST_AFTER: fast_after_r <= cfg_data[9:0];
        ttdos_pkg::CFG_SLOW_SPEED: slow_speed_r <= cfg_data[6:0];
        ttdos_pkg::CFG_FAST_SPEED: fast_speed_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register. It refills in the same cycle as its item moves on to
  // the compute stage, so the pipe sustains one transfer per cycle while out_ready allows.
  // ---------------------------------------------------------------------
  logic                in_vld_r;
  ttdos_pkg::op_t      in_op_r;
  logic [11:0]         in_left_r, in_right_r;
  logic [15:0]         in_id_r;
  logic signed [8:0]   in_turn_r;
  logic signed [15:0]  in_dist_r;
  logic                advance;

  assign advance  = in_vld_r && (!out_valid || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op_r    <= ttdos_pkg::op_t'(in_op);
      in_left_r  <= in_adc_left;
      in_right_r <= in_adc_right;
      in_id_r    <= in_order_id;
      in_turn_r  <= in_turn_degree;
      in_dist_r  <= in_drive_distance;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer state.
  // ---------------------------------------------------------------------
  logic signed [8:0]       heading_r, heading_nxt;
  logic [15:0]             saved_id_r, saved_id_nxt;
  logic signed [8:0]       saved_turn_r, saved_turn_nxt;
  logic signed [15:0]      saved_dist_r, saved_dist_nxt;
  // Whole 4.8-degree steps of the current turn, worked out when the order
  // arrives so that a poll tick only needs a constant scale and a compare.
  logic [5:0]              steps_r, steps_nxt;
  logic [15:0]             goal_r, goal_nxt;
  logic [TRAVEL_BITS-1:0]  left_trav_r, left_trav_nxt;
  logic [TRAVEL_BITS-1:0]  right_trav_r, right_trav_nxt;
  logic                    left_pulse_r, left_pulse_nxt;
  logic                    right_pulse_r, right_pulse_nxt;
  ttdos_pkg::phase_t       phase_r, phase_nxt;
  logic                    pending_r, pending_nxt;

  // Result register.
  logic                    out_valid_r;
  ttdos_pkg::cmd_t         cmd_r, cmd_nxt;
  logic [6:0]              speed_r, speed_nxt;
  ttdos_pkg::ev_t          ev_r, ev_nxt;
  logic [15:0]             rep_id_r;
  logic signed [8:0]       rep_turn_r;
  logic signed [15:0]      rep_dist_r;

  // Sensor samples with the fixed offset of two.
  logic [12:0]             left_v, right_v;
  logic [TRAVEL_BITS:0]    left_add, right_add;
  logic [TRAVEL_BITS-1:0]  left_sat, right_sat;

  assign left_v  = 13'(in_left_r) + ttdos_pkg::SAMPLE_OFFSET;
  assign right_v = 13'(in_right_r) + ttdos_pkg::SAMPLE_OFFSET;

  // Saturating travel increments.
  assign left_add  = {1'b0, left_trav_r} + (TRAVEL_BITS + 1)'(pulse_step_r);
  assign right_add = {1'b0, right_trav_r} + (TRAVEL_BITS + 1)'(pulse_step_r);
  assign left_sat  = left_add[TRAVEL_BITS] ? '1 : left_add[TRAVEL_BITS-1:0];
  assign right_sat = right_add[TRAVEL_BITS] ? '1 : right_add[TRAVEL_BITS-1:0];

  // Poll tick compares.
  logic [TRAVEL_BITS-1:0]  turn_limit;
  logic [SUM_W-1:0]        trav_sum, fast_limit, goal_limit;
  logic                    turn_done, past_fast, at_goal;

  assign turn_limit = TRAVEL_BITS'(steps_r) * TRAVEL_BITS'(100);
  assign turn_done  = right_trav_r > turn_limit;
  assign trav_sum   = SUM_W'(left_trav_r) + SUM_W'(right_trav_r);
  assign fast_limit = SUM_W'(fast_after_r) * SUM_W'(200);
  assign goal_limit = SUM_W'(goal_r) * SUM_W'(200);
  assign past_fast  = trav_sum > fast_limit;
  assign at_goal    = trav_sum >= goal_limit;

  // New order: heading wrap and turn magnitude.
  logic signed [10:0]      head_sum;
  logic [8:0]              turn_abs;
  logic [7:0]              turn_mag;

  assign head_sum = 11'(heading_r) + 11'(in_turn_r);
  assign turn_abs = in_turn_r[8] ? 9'(-in_turn_r) : 9'(in_turn_r);
  assign turn_mag = turn_abs[8] ? 8'hFF : turn_abs[7:0];

  always_comb begin
    heading_nxt     = heading_r;
    saved_id_nxt    = saved_id_r;
    saved_turn_nxt  = saved_turn_r;
    saved_dist_nxt  = saved_dist_r;
    steps_nxt       = steps_r;
    goal_nxt        = goal_r;
    left_trav_nxt   = left_trav_r;
    right_trav_nxt  = right_trav_r;
    left_pulse_nxt  = left_pulse_r;
    right_pulse_nxt = right_pulse_r;
    phase_nxt       = phase_r;
    pending_nxt     = pending_r;
    cmd_nxt         = ttdos_pkg::CMD_KEEP;
    speed_nxt       = '0;
    ev_nxt          = ttdos_pkg::EV_NONE;

    case (in_op_r)
      ttdos_pkg::OP_SAMPLE: begin
        // Hysteresis detectors; the high test is made first.
        if (left_v > left_high_r) begin
          if (!left_pulse_r) begin
            left_pulse_nxt = 1'b1;
            left_trav_nxt  = left_sat;
          end
        end else if (left_v < left_low_r) begin
          left_pulse_nxt = 1'b0;
        end
        if (right_v > right_high_r) begin
          if (!right_pulse_r) begin
            right_pulse_nxt = 1'b1;
            right_trav_nxt  = right_sat;
          end
        end else if (right_v < right_low_r) begin
          right_pulse_nxt = 1'b0;
        end
      end

      ttdos_pkg::OP_POLL: begin
        if (phase_r.turn) begin
          if (steps_r != '0) begin
            if (turn_done) begin
              goal_nxt       = '0;
              phase_nxt      = '{run: 1'b0, drive: 1'b1, turn: 1'b0};
              cmd_nxt        = ttdos_pkg::CMD_STOP;
              left_trav_nxt  = '0;
              right_trav_nxt = '0;
            end
          end else begin
            // A turn of under one step is dropped without a command.
            phase_nxt.turn  = 1'b0;
            phase_nxt.drive = 1'b1;
          end
        end else if (phase_r.drive) begin
          if (!phase_r.run) begin
            if (!saved_dist_r[15]) begin
              cmd_nxt  = ttdos_pkg::CMD_FORWARD;
              goal_nxt = saved_dist_r;
            end else begin
              cmd_nxt  = ttdos_pkg::CMD_BACKWARD;
              goal_nxt = 16'(-saved_dist_r);
            end
            speed_nxt     = slow_speed_r;
            phase_nxt.run = 1'b1;
          end else begin
            if (past_fast) begin
              if (!saved_dist_r[15] && saved_dist_r != '0) begin
                cmd_nxt   = ttdos_pkg::CMD_FORWARD;
                speed_nxt = fast_speed_r;
              end else if (saved_dist_r[15]) begin
                cmd_nxt   = ttdos_pkg::CMD_BACKWARD;
                speed_nxt = fast_speed_r;
              end
            end
            // Reaching the goal wins over the speed change.
            if (at_goal) begin
              cmd_nxt        = ttdos_pkg::CMD_STOP;
              speed_nxt      = '0;
              phase_nxt      = '0;
              left_trav_nxt  = '0;
              right_trav_nxt = '0;
            end
          end
        end else if (pending_r) begin
          phase_nxt.run = 1'b0;
          ev_nxt        = ttdos_pkg::EV_REPORT;
          pending_nxt   = 1'b0;
        end
      end

      ttdos_pkg::OP_ORDER: begin
        saved_id_nxt   = in_id_r;
        saved_dist_nxt = in_dist_r;
        saved_turn_nxt = in_turn_r;
        if (head_sum < -11'sd180) begin
          heading_nxt = 9'(head_sum + 11'sd360);
        end else if (head_sum > 11'sd180) begin
          heading_nxt = 9'(head_sum - 11'sd360);
        end else begin
          heading_nxt = 9'(head_sum);
        end
        phase_nxt.run = 1'b0;
        if (in_turn_r != '0) begin
          phase_nxt.turn = 1'b1;
          steps_nxt      = ttdos_pkg::turn_steps(turn_mag);
          cmd_nxt        = in_turn_r[8] ? ttdos_pkg::CMD_TURN_NEG : ttdos_pkg::CMD_TURN_POS;
          speed_nxt      = ttdos_pkg::TURN_SPEED;
          left_trav_nxt  = '0;
          right_trav_nxt = '0;
        end else begin
          phase_nxt.drive = 1'b1;
        end
        pending_nxt = 1'b1;
        ev_nxt      = ttdos_pkg::EV_ACCEPTED;
      end

      ttdos_pkg::OP_CLEAR: begin
        goal_nxt       = '0;
        steps_nxt      = '0;
        phase_nxt      = '0;
        pending_nxt    = 1'b0;
        left_trav_nxt  = '0;
        right_trav_nxt = '0;
        cmd_nxt        = ttdos_pkg::CMD_STOP;
        ev_nxt         = ttdos_pkg::EV_CLEARED;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r     <= '0;
      saved_id_r    <= '0;
      saved_turn_r  <= '0;
      saved_dist_r  <= '0;
      steps_r       <= '0;
      goal_r        <= '0;
      left_trav_r   <= '0;
      right_trav_r  <= '0;
      left_pulse_r  <= 1'b0;
      right_pulse_r <= 1'b0;
      phase_r       <= '0;
      pending_r     <= 1'b0;
    end else if (advance) begin
      heading_r     <= heading_nxt;
      saved_id_r    <= saved_id_nxt;
      saved_turn_r  <= saved_turn_nxt;
      saved_dist_r  <= saved_dist_nxt;
      steps_r       <= steps_nxt;
      goal_r        <= goal_nxt;
      left_trav_r   <= left_trav_nxt;
      right_trav_r  <= right_trav_nxt;
      left_pulse_r  <= left_pulse_nxt;
      right_pulse_r <= right_pulse_nxt;
      phase_r       <= phase_nxt;
      pending_r     <= pending_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd_r   <= cmd_nxt;
      speed_r <= speed_nxt;
      ev_r    <= ev_nxt;
      if (ev_nxt == ttdos_pkg::EV_REPORT) begin
        rep_id_r   <= saved_id_r;
        rep_turn_r <= saved_turn_r;
        rep_dist_r <= saved_dist_r;
      end else begin
        rep_id_r   <= '0;
        rep_turn_r <= '0;
        rep_dist_r <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_motor_cmd       = cmd_r;
  assign out_motor_speed     = speed_r;
  assign out_heading         = heading_r;
  assign out_event_res       = ev_r;
  assign out_report_order_id = rep_id_r;
  assign out_report_degree   = rep_turn_r;
  assign out_report_distance = rep_dist_r;

  // Assertions.
  a_run_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r.run |-> phase_r.drive)
    else $error("run flag set without drive flag");

  a_no_turn_while_run: assert property (@(posedge clk) disable iff (!rst_n)
    !(phase_r.turn && phase_r.run))
    else $error("turn and run flags set together");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (heading_r >= -9'sd180) && (heading_r <= 9'sd180))
    else $error("heading outside -180..180");

  a_report_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r != ttdos_pkg::EV_REPORT) |->
      (rep_id_r == '0 && rep_turn_r == '0 && rep_dist_r == '0))
    else $error("report fields nonzero without report event");

endmodule

>>> verif/turn_then_drive_odometry_sequencer_unit_tb.sv
module turn_then_drive_odometry_sequencer_unit_tb;
  // Self-checking bench for the turn-then-drive odometry sequencer. A driver
  // block feeds input transfers from a queue that the stimulus process fills,
  // and a monitor block takes result transfers. Every accepted input is run
  // through a local model of the sequencer, which holds its own copy of the
  // state and of the configuration. The result that the model works out is
  // put in a queue of results still due. Results leave the block in order, one
  // for each input transfer, so each result transfer is checked against the
  // oldest entry in that queue.

  localparam int TB = ttdos_pkg::TRAVEL_BITS_DEF;
  // A generous ceiling on the whole run, in clock cycles.
  localparam int LIMIT_CYCLES = 1_000_000;

  // One input item, as carried by one input transfer.
  typedef struct packed {
    ttdos_pkg::op_t     op;
    logic [11:0]        adc_l;
    logic [11:0]        adc_r;
    logic [15:0]        id;
    logic signed [8:0]  deg;
    logic signed [15:0] distance;
  } item_t;

  // One result item, as carried by one result transfer.
  typedef struct packed {
    ttdos_pkg::cmd_t    cmd;
    logic [6:0]         speed;
    logic signed [8:0]  heading;
    ttdos_pkg::ev_t     ev;
    logic [15:0]        rep_id;
    logic signed [8:0]  rep_deg;
    logic signed [15:0] rep_dist;
  } result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_op = ttdos_pkg::OP_SAMPLE;
  logic [11:0]        in_adc_left = '0;
  logic [11:0]        in_adc_right = '0;
  logic [15:0]        in_order_id = '0;
  logic signed [8:0]  in_turn_degree = '0;
  logic signed [15:0] in_drive_distance = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_motor_cmd;
  logic [6:0]         out_motor_speed;
  logic signed [8:0]  out_heading;
  logic [1:0]         out_event_res;
  logic [15:0]        out_report_order_id;
  logic signed [8:0]  out_report_degree;
  logic signed [15:0] out_report_distance;

  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = ttdos_pkg::CFG_LEFT_HIGH;
  logic [12:0] cfg_data = '0;

  // When set, neither side idles: this gives the long stretch at full rate.
  logic steady = 1'b0;

  item_t   queued_items[$];
  result_t reports_due[$];
  item_t   drv_item;
  int      sent_count = 0;
  int      bad_results = 0;

  turn_then_drive_odometry_sequencer_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_adc_left         (in_adc_left),
    .in_adc_right        (in_adc_right),
    .in_order_id         (in_order_id),
    .in_turn_degree      (in_turn_degree),
    .in_drive_distance   (in_drive_distance),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_motor_cmd       (out_motor_cmd),
    .out_motor_speed     (out_motor_speed),
    .out_heading         (out_heading),
    .out_event_res       (out_event_res),
    .out_report_order_id (out_report_order_id),
    .out_report_degree   (out_report_degree),
    .out_report_distance (out_report_distance),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Local model of the sequencer: configuration first, then state.
  // ---------------------------------------------------------------------------
  logic [12:0] thr_lh, thr_ll, thr_rh, thr_rl;
  logic [9:0]  step_hund, fast_units;
  logic [6:0]  spd_slow, spd_fast;

  logic signed [8:0]  head;
  logic [15:0]        ord_id;
  logic signed [8:0]  ord_turn;
  logic signed [15:0] ord_dist;
  logic [7:0]         turn_mag;
  logic [15:0]        goal;
  logic [TB-1:0]      trav_l, trav_r;
  logic               pulse_l, pulse_r;
  ttdos_pkg::phase_t  phase;
  logic               report_due;

  // One side's hysteresis detector. The sample is offset by two, and the high
  // test is made first, so crossed thresholds still behave in a defined way.
  // A rising pulse adds one step to the travel, which saturates rather than
  // wrapping. The new pulse flag and travel come back packed together.
  function automatic logic [TB:0] hyst(input logic [11:0] s, input logic [12:0] hi,
                                       input logic [12:0] lo, input logic pulse,
                                       input logic [TB-1:0] trav);
    logic [12:0] v;
    logic [TB:0] sum;
    v = {1'b0, s} + 13'd2;
    sum = {1'b0, trav} + (TB + 1)'(step_hund);
    if (v > hi) begin
      if (!pulse) begin
        pulse = 1'b1;
        trav = sum[TB] ? '1 : sum[TB-1:0];
      end
    end else if (v < lo) begin
      pulse = 1'b0;
    end
    return {pulse, trav};
  endfunction

  // Advances the model by one input item and gives back the result it causes.
  function automatic result_t advance_sequencer(input item_t it);
    result_t res;
    int      steps;
    int      h;
    int      m;
    longint  both;
    res = '0;
    case (it.op)
      ttdos_pkg::OP_SAMPLE: begin
        {pulse_l, trav_l} = hyst(it.adc_l, thr_lh, thr_ll, pulse_l, trav_l);
        {pulse_r, trav_r} = hyst(it.adc_r, thr_rh, thr_rl, pulse_r, trav_r);
      end
      ttdos_pkg::OP_POLL: begin
        if (phase.turn) begin
          // The turn length is counted in whole steps of 4.8 degrees.
          steps = (int'(turn_mag) * 10) / 48;
          if (steps != 0) begin
            if (longint'(trav_r) > longint'(steps) * 100) begin
              goal = '0;
              phase = '0;
              phase.drive = 1'b1;
              res.cmd = ttdos_pkg::CMD_STOP;
              trav_l = '0;
              trav_r = '0;
            end
          end else begin
            // A turn too short for one step is dropped without a command.
            phase.turn = 1'b0;
            phase.drive = 1'b1;
          end
        end else if (phase.drive) begin
          if (!phase.run) begin
            if (ord_dist >= 0) begin
              res.cmd = ttdos_pkg::CMD_FORWARD;
              goal = ord_dist;
            end else begin
              res.cmd = ttdos_pkg::CMD_BACKWARD;
              goal = -ord_dist;
            end
            res.speed = spd_slow;
            phase.run = 1'b1;
          end else begin
            // Left plus right is twice the mean travel, hence the factor 200.
            both = longint'(trav_l) + longint'(trav_r);
            if (both > longint'(fast_units) * 200) begin
              if (ord_dist > 0) begin
                res.cmd = ttdos_pkg::CMD_FORWARD;
                res.speed = spd_fast;
              end else if (ord_dist < 0) begin
                res.cmd = ttdos_pkg::CMD_BACKWARD;
                res.speed = spd_fast;
              end
            end
            // Reaching the goal wins over the change to fast speed.
            if (both >= longint'(goal) * 200) begin
              res.cmd = ttdos_pkg::CMD_STOP;
              res.speed = '0;
              phase = '0;
              trav_l = '0;
              trav_r = '0;
            end
          end
        end else if (report_due) begin
          phase.run = 1'b0;
          res.ev = ttdos_pkg::EV_REPORT;
          report_due = 1'b0;
        end
      end
      ttdos_pkg::OP_ORDER: begin
        ord_id = it.id;
        ord_dist = it.distance;
        ord_turn = it.deg;
        phase.run = 1'b0;
        // The heading is wrapped once into the range of a half turn each way.
        h = int'(head) + int'(it.deg);
        if (h < -180) h += 360;
        else if (h > 180) h -= 360;
        head = 9'(h);
        if (it.deg != 0) begin
          m = (it.deg > 0) ? int'(it.deg) : -int'(it.deg);
          phase.turn = 1'b1;
          turn_mag = (m > 255) ? 8'd255 : 8'(m);
          res.cmd = (it.deg > 0) ? ttdos_pkg::CMD_TURN_POS : ttdos_pkg::CMD_TURN_NEG;
          res.speed = ttdos_pkg::TURN_SPEED;
          trav_l = '0;
          trav_r = '0;
        end else begin
          phase.drive = 1'b1;
        end
        report_due = 1'b1;
        res.ev = ttdos_pkg::EV_ACCEPTED;
      end
      default: begin
        goal = '0;
        turn_mag = '0;
        phase = '0;
        report_due = 1'b0;
        trav_l = '0;
        trav_r = '0;
        res.cmd = ttdos_pkg::CMD_STOP;
        res.ev = ttdos_pkg::EV_CLEARED;
      end
    endcase
    res.heading = head;
    if (res.ev == ttdos_pkg::EV_REPORT) begin
      res.rep_id = ord_id;
      res.rep_deg = ord_turn;
      res.rep_dist = ord_dist;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and the overall time limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("turn_then_drive_odometry_sequencer_unit_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver. An input transfer completes at an edge where valid and ready are
  // both high; that is the moment the item enters the model. Valid is then
  // either kept high with the next item or dropped, with a single assignment
  // per edge, and it never waits for ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_inputs
    logic taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) reports_due.push_back(advance_sequencer(drv_item));
      if (!in_valid || taken) begin
        if (queued_items.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
          drv_item = queued_items.pop_front();
          in_valid <= 1'b1;
          in_op <= drv_item.op;
          in_adc_left <= drv_item.adc_l;
          in_adc_right <= drv_item.adc_r;
          in_order_id <= drv_item.id;
          in_turn_degree <= drv_item.deg;
          in_drive_distance <= drv_item.distance;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Outputs are sampled at the edge, before the block updates them,
  // so a result transfer is seen exactly where the handshake completes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    result_t seen;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      seen.cmd = ttdos_pkg::cmd_t'(out_motor_cmd);
      seen.speed = out_motor_speed;
      seen.heading = out_heading;
      seen.ev = ttdos_pkg::ev_t'(out_event_res);
      seen.rep_id = out_report_order_id;
      seen.rep_deg = out_report_degree;
      seen.rep_dist = out_report_distance;
      if (reports_due.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result transfer: cmd %0d speed %0d heading %0d ev %0d",
                   seen.cmd, seen.speed, seen.heading, seen.ev);
      end else begin
        want = reports_due.pop_front();
        if (seen !== want) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("mismatch: expected cmd %0d spd %0d head %0d ev %0d id %0d deg %0d len %0d",
                     want.cmd, want.speed, want.heading, want.ev,
                     want.rep_id, want.rep_deg, want.rep_dist);
            $display("          actual   cmd %0d spd %0d head %0d ev %0d id %0d deg %0d len %0d",
                     seen.cmd, seen.speed, seen.heading, seen.ev,
                     seen.rep_id, seen.rep_deg, seen.rep_dist);
          end
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 21);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // An item of the given operation with every field filled at random, so that
  // the fields the operation ignores still see all their bits toggle.
  function automatic item_t junk(input ttdos_pkg::op_t op);
    item_t it;
    it.op = op;
    it.adc_l = 12'($urandom);
    it.adc_r = 12'($urandom);
    it.id = 16'($urandom);
    it.deg = 9'($urandom);
    it.distance = 16'($urandom);
    return it;
  endfunction

  // A sample that starts a pulse under the given high threshold, where one can.
  function automatic logic [11:0] hi_lvl(input logic [12:0] thr);
    if (thr > 13'd4096) return 12'd4095;
    return 12'($urandom_range(4095, (thr == 0) ? 0 : int'(thr) - 1));
  endfunction

  // A sample that ends a pulse under the given low threshold, where one can.
  function automatic logic [11:0] lo_lvl(input logic [12:0] thr);
    int top;
    if (thr < 13'd3) return 12'd0;
    top = int'(thr) - 3;
    if (top > 4095) top = 4095;
    return 12'($urandom_range(top, 0));
  endfunction

  task automatic push(input item_t it);
    queued_items.push_back(it);
    sent_count++;
  endtask

  task automatic push_order(input logic [15:0] id, input int deg, input int distance);
    item_t it;
    it = junk(ttdos_pkg::OP_ORDER);
    it.id = id;
    it.deg = 9'(deg);
    it.distance = 16'(distance);
    push(it);
  endtask

  task automatic push_sample(input logic [11:0] l, input logic [11:0] r);
    item_t it;
    it = junk(ttdos_pkg::OP_SAMPLE);
    it.adc_l = l;
    it.adc_r = r;
    push(it);
  endtask

  // One rising and one falling wheel pulse on both sides.
  task automatic push_pulse();
    push_sample(hi_lvl(thr_lh), hi_lvl(thr_rh));
    push_sample(lo_lvl(thr_ll), lo_lvl(thr_rl));
  endtask

  // A well-formed order: mostly a modest turn and distance, then wheel pulses mixed
  // with poll ticks, so that turns end, drives speed up and stop, and the
  // finished order gets reported. Now and then a clear or a fresh order
  // breaks the sequence part way.
  task automatic push_mission();
    int r;
    int deg;
    int distance;
    r = $urandom_range(99);
    if (r < 10) deg = 0;
    else if (r < 75) deg = $urandom_range(120) - 60;
    else if (r < 95) deg = $urandom_range(360) - 180;
    else deg = $urandom_range(511) - 256;
    r = $urandom_range(99);
    if (r < 10) distance = 0;
    else if (r < 85) distance = $urandom_range(40) - 20;
    else distance = $urandom_range(65534) - 32767;
    push_order(16'($urandom), deg, distance);
    repeat ($urandom_range(60, 15)) begin
      r = $urandom_range(99);
      if (r < 45) push_pulse();
      else if (r < 55) push(junk(ttdos_pkg::OP_SAMPLE));
      else if (r < 96) push(junk(ttdos_pkg::OP_POLL));
      else if (r < 98) push(junk(ttdos_pkg::OP_CLEAR));
      else push_order(16'($urandom), $urandom_range(120) - 60, $urandom_range(20) - 10);
    end
    repeat (3) push(junk(ttdos_pkg::OP_POLL));
  endtask

  // Waits until every queued item has gone in and every result has come out,
  // then lets the block's two-stage pipeline settle.
  task automatic drain();
    while (queued_items.size() != 0 || in_valid || reports_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register while the block is idle and mirrors it in the model.
  task automatic write_reg(input ttdos_pkg::cfg_idx_t idx, input logic [12:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ttdos_pkg::CFG_LEFT_HIGH:  thr_lh = val;
      ttdos_pkg::CFG_LEFT_LOW:   thr_ll = val;
      ttdos_pkg::CFG_RIGHT_HIGH: thr_rh = val;
      ttdos_pkg::CFG_RIGHT_LOW:  thr_rl = val;
      ttdos_pkg::CFG_PULSE_STEP: step_hund = val[9:0];
      ttdos_pkg::CFG_FAST_AFTER: fast_units = val[9:0];
      ttdos_pkg::CFG_SLOW_SPEED: spd_slow = val[6:0];
      default:                   spd_fast = val[6:0];
    endcase
  endtask

  task automatic load_config(input logic [12:0] lh, input logic [12:0] ll,
                             input logic [12:0] rh, input logic [12:0] rl,
                             input logic [12:0] step, input logic [12:0] fast_at,
                             input logic [12:0] slow, input logic [12:0] fast);
    write_reg(ttdos_pkg::CFG_LEFT_HIGH, lh);
    write_reg(ttdos_pkg::CFG_LEFT_LOW, ll);
    write_reg(ttdos_pkg::CFG_RIGHT_HIGH, rh);
    write_reg(ttdos_pkg::CFG_RIGHT_LOW, rl);
    write_reg(ttdos_pkg::CFG_PULSE_STEP, step);
    write_reg(ttdos_pkg::CFG_FAST_AFTER, fast_at);
    write_reg(ttdos_pkg::CFG_SLOW_SPEED, slow);
    write_reg(ttdos_pkg::CFG_FAST_SPEED, fast);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed orders, with some bursts of items of any kind.
  task automatic run_random(input int count);
    int stop_at;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < 85) push_mission();
      else repeat (8) push(junk(ttdos_pkg::op_t'($urandom_range(3))));
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int lo_val;
    thr_lh = ttdos_pkg::LEFT_HIGH_RST;
    thr_ll = ttdos_pkg::LEFT_LOW_RST;
    thr_rh = ttdos_pkg::RIGHT_HIGH_RST;
    thr_rl = ttdos_pkg::RIGHT_LOW_RST;
    step_hund = ttdos_pkg::PULSE_STEP_RST;
    fast_units = ttdos_pkg::FAST_AFTER_RST;
    spd_slow = ttdos_pkg::SLOW_SPEED_RST;
    spd_fast = ttdos_pkg::FAST_SPEED_RST;
    head = '0;
    ord_id = '0;
    ord_turn = '0;
    ord_dist = '0;
    turn_mag = '0;
    goal = '0;
    trav_l = '0;
    trav_r = '0;
    pulse_l = 1'b0;
    pulse_r = 1'b0;
    phase = '0;
    report_due = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, at the reset configuration. Samples at the extremes and
    // right on the left high threshold, where an offset sample equal to the
    // threshold must not start a pulse and one above it must.
    push_sample(12'd0, 12'd0);
    push_sample(12'd4095, 12'd4095);
    push_sample(12'd4095, 12'd4095);
    push_sample(12'd0, 12'd0);
    push_sample(12'd1898, 12'd2548);
    push_sample(12'd1899, 12'd2549);
    push(junk(ttdos_pkg::OP_POLL));
    // Extreme orders: the heading wraps both ways, and a turn of -256 is
    // clamped to a magnitude of 255.
    push_order(16'hFFFF, 180, 32767);
    push_order(16'h0000, -180, -32767);
    push_order(16'h0001, -256, 0);
    push_order(16'h0002, 255, 0);
    // A turn shorter than one step, then a zero-length drive to its report.
    push_order(16'h1234, 4, 0);
    repeat (5) push(junk(ttdos_pkg::OP_POLL));
    // A zero-turn order, then a second one arriving while the first drives.
    push_order(16'h5A5A, 0, -5);
    push(junk(ttdos_pkg::OP_POLL));
    push_order(16'hA5A5, 0, 3);
    push(junk(ttdos_pkg::OP_POLL));
    push(junk(ttdos_pkg::OP_CLEAR));
    drain();

    run_random(400);

    // Extreme settings: the left detector fires on any sample and never
    // rearms below zero; the right one can never reach its high threshold.
    load_config(13'd0, 13'd0, 13'd4097, 13'd4097, 13'd1023, 13'd0, 13'd0, 13'd100);
    run_random(300);

    // The opposite extremes, with the smallest nonzero step and the latest fast speed.
    load_config(13'd4097, 13'd4097, 13'd0, 13'd0, 13'd1, 13'd1023, 13'd100, 13'd0);
    run_random(300);

    // Crossed thresholds, where the low threshold lies above the high one, run
    // at full rate on both sides.
    steady = 1'b1;
    load_config(13'd1000, 13'd3000, 13'd1200, 13'd2800,
                13'($urandom_range(1023, 1)), 13'($urandom_range(30)),
                13'($urandom_range(100)), 13'($urandom_range(100)));
    run_random(300);
    steady = 1'b0;

    // A random ordinary setting.
    lo_val = $urandom_range(3000, 100);
    load_config(13'($urandom_range(4000, lo_val)), 13'(lo_val),
                13'($urandom_range(4000, lo_val)), 13'(lo_val),
                13'($urandom_range(400, 50)), 13'($urandom_range(25)),
                13'($urandom_range(100)), 13'($urandom_range(100)));
    run_random(500);

    repeat (8) @(posedge clk);
    if (bad_results == 0) begin
      $display("turn_then_drive_odometry_sequencer_unit_tb: PASS");
    end else begin
      $display("turn_then_drive_odometry_sequencer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
